// ----- design/qte_pkg.sv -----
// Shared types, constants and the arctangent table for the quaternion to Euler converter.
package qte_pkg;

   localparam int QUAT_W      = 16;
   localparam int PROD_W      = 32;
   localparam int TERM_W      = 35;
   localparam int S_W         = 30;
   localparam int RAD_W       = 58;
   localparam int ROOT_W      = 29;
   localparam int SQRT_STEPS  = 29;
   localparam int ROLL_W      = 16;
   localparam int PITCH_W     = 15;
   localparam int YAW_W       = 16;
   localparam int GS_W        = 2;
   localparam int TOL_W       = 8;
   localparam int Z_W         = 28;
   localparam int ATAN_TAB_LEN = 24;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;
   localparam int HALF_PI_Z   = 26353589;
   localparam int PI_Q13      = 25736;
   localparam int HALF_PI_Q13 = 12868;
   localparam int ROUND_BIAS  = 1024;
   localparam int ROUND_SHIFT = 11;

   typedef enum logic [GS_W-1:0] {
      GS_NORMAL   = 2'd0,
      GS_LOCK_POS = 2'd1,
      GS_LOCK_NEG = 2'd2
   } gimbal_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] xz;
      logic signed [PROD_W-1:0] wy;
      logic signed [PROD_W-1:0] yz;
      logic signed [PROD_W-1:0] wx;
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] yy;
      logic signed [PROD_W-1:0] xy;
      logic signed [PROD_W-1:0] wz;
      logic signed [PROD_W-1:0] zz;
   } prod_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] m21;
      logic signed [TERM_W-1:0] m22;
      logic signed [TERM_W-1:0] m10;
      logic signed [TERM_W-1:0] m00;
      logic signed [TERM_W-1:0] m01;
      logic signed [TERM_W-1:0] m02;
   } terms_type;

   // atan(2^-i) in units of 2^-24 rad
   function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0:  v = 28'sd13176795;
         1:  v = 28'sd7778716;
         2:  v = 28'sd4110060;
         3:  v = 28'sd2086331;
         4:  v = 28'sd1047214;
         5:  v = 28'sd524117;
         6:  v = 28'sd262123;
         7:  v = 28'sd131069;
         8:  v = 28'sd65536;
         9:  v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/qte_front.sv -----
// Request intake: registers the quaternion component products for the queue.
module qte_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [qte_pkg::QUAT_W-1:0] req_quat_w,
   input  logic signed [qte_pkg::QUAT_W-1:0] req_quat_x,
   input  logic signed [qte_pkg::QUAT_W-1:0] req_quat_y,
   input  logic signed [qte_pkg::QUAT_W-1:0] req_quat_z,
   output logic                              push_valid,
   input  logic                              push_ready,
   output qte_pkg::prod_type                 push_data
);
   import qte_pkg::*;

   logic     valid_ff, valid_in;
   prod_type prod_ff, prod_in;

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_data  = prod_ff;

   always_comb begin
      valid_in   = req_ready ? req_valid : valid_ff;
      prod_in.xz = PROD_W'(req_quat_x) * PROD_W'(req_quat_z);
      prod_in.wy = PROD_W'(req_quat_w) * PROD_W'(req_quat_y);
      prod_in.yz = PROD_W'(req_quat_y) * PROD_W'(req_quat_z);
      prod_in.wx = PROD_W'(req_quat_w) * PROD_W'(req_quat_x);
      prod_in.xx = PROD_W'(req_quat_x) * PROD_W'(req_quat_x);
      prod_in.yy = PROD_W'(req_quat_y) * PROD_W'(req_quat_y);
      prod_in.xy = PROD_W'(req_quat_x) * PROD_W'(req_quat_y);
      prod_in.wz = PROD_W'(req_quat_w) * PROD_W'(req_quat_z);
      prod_in.zz = PROD_W'(req_quat_z) * PROD_W'(req_quat_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- design/qte_queue.sv -----
// Short request queue between the intake and the angle pipeline.
module qte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  qte_pkg::prod_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output qte_pkg::prod_type pop_data
);
   import qte_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   prod_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

// ----- design/qte_cordic.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) rounded to Q3.13 radians.
module qte_cordic #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEFAULT,
   parameter int IN_W  = qte_pkg::TERM_W
) (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [IN_W-1:0]            in_x,
   input  logic signed [IN_W-1:0]            in_y,
   output logic signed [qte_pkg::ROLL_W-1:0] angle
);
   import qte_pkg::*;

   localparam int XW = IN_W + 2;
   localparam logic signed [Z_W-1:0]    HALF_Z = Z_W'(HALF_PI_Z);
   localparam logic signed [ROLL_W:0]   PI_LIM = (ROLL_W + 1)'(PI_Q13);

   logic signed [XW-1:0]  x_ff [STEPS+1];
   logic signed [XW-1:0]  y_ff [STEPS+1];
   logic signed [Z_W-1:0] z_ff [STEPS+1];
   logic [STEPS:0]        zero_ff;
   logic signed [XW-1:0]  x_nx [STEPS];
   logic signed [XW-1:0]  y_nx [STEPS];
   logic signed [Z_W-1:0] z_nx [STEPS];
   logic signed [XW-1:0]  pre_x, pre_y, ext_x, ext_y;
   logic signed [Z_W-1:0] pre_z, z_round;
   logic signed [ROLL_W:0]   z_short;
   logic signed [ROLL_W-1:0] angle_ff, angle_in;

   assign angle = angle_ff;

   // quadrant pre-rotation by a quarter turn when x is negative
   always_comb begin
      ext_x = XW'(in_x);
      ext_y = XW'(in_y);
      pre_x = ext_x;
      pre_y = ext_y;
      pre_z = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            pre_x = ext_y;
            pre_y = -ext_x;
            pre_z = HALF_Z;
         end else begin
            pre_x = -ext_y;
            pre_y = ext_x;
            pre_z = -HALF_Z;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         if (y_ff[i] > 0) begin
            x_nx[i] = x_ff[i] + (y_ff[i] >>> i);
            y_nx[i] = y_ff[i] - (x_ff[i] >>> i);
            z_nx[i] = z_ff[i] + atan_entry(i);
         end else begin
            x_nx[i] = x_ff[i] - (y_ff[i] >>> i);
            y_nx[i] = y_ff[i] + (x_ff[i] >>> i);
            z_nx[i] = z_ff[i] - atan_entry(i);
         end
      end
   end

   always_comb begin
      z_round = (z_ff[STEPS] + Z_W'(ROUND_BIAS)) >>> ROUND_SHIFT;
      z_short = z_round[ROLL_W:0];
      if (zero_ff[STEPS]) begin
         angle_in = '0;
      end else if (z_short > PI_LIM) begin
         angle_in = ROLL_W'(PI_LIM);
      end else if (z_short < -PI_LIM) begin
         angle_in = ROLL_W'(-PI_LIM);
      end else begin
         angle_in = z_short[ROLL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= pre_x;
         y_ff[0]    <= pre_y;
         z_ff[0]    <= pre_z;
         zero_ff[0] <= (in_x == 0) && (in_y == 0);
         for (int i = 0; i < STEPS; i++) begin
            x_ff[i+1]    <= x_nx[i];
            y_ff[i+1]    <= y_nx[i];
            z_ff[i+1]    <= z_nx[i];
            zero_ff[i+1] <= zero_ff[i];
         end
         angle_ff <= angle_in;
      end
   end

endmodule

// ----- design/qte_back.sv -----
// Angle pipeline: matrix terms, pitch sine and cosine, five CORDICs, gimbal selection.
module qte_back #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  qte_pkg::prod_type                   pop_data,
   input  logic                                csr_write_enable,
   input  logic [qte_pkg::TOL_W-1:0]           csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [qte_pkg::ROLL_W-1:0]   rsp_roll_angle,
   output logic signed [qte_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   output logic signed [qte_pkg::YAW_W-1:0]    rsp_yaw_angle,
   output logic [qte_pkg::GS_W-1:0]            rsp_gimbal_state
);
   import qte_pkg::*;

   localparam int CORDIC_LAT = CORDIC_STEPS + 2;
   localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd1 <<< 28);
   localparam logic [RAD_W-1:0]         ONE_Q56 = RAD_W'(64'd1 << 56);
   localparam logic signed [ROLL_W-1:0] HALF_LIM = ROLL_W'(HALF_PI_Q13);

   logic adv;
   logic [TOL_W-1:0] tol_ff;

   // term stage
   logic                     a_valid_ff;
   logic signed [TERM_W-1:0] a_m20_ff, a_m20_in;
   terms_type                a_terms_ff, a_terms_in;
   // sine stage
   logic                     b_valid_ff;
   logic signed [S_W-1:0]    b_s_ff, b_s_in;
   logic signed [TERM_W-1:0] neg_m20;
   terms_type                b_terms_ff;
   // square stage
   logic                     c_valid_ff;
   logic signed [2*S_W-1:0]  sq;
   logic [RAD_W-1:0]         c_rem_ff;
   logic signed [S_W-1:0]    c_s_ff;
   terms_type                c_terms_ff;
   // root stages
   logic [SQRT_STEPS-1:0]    q_valid_ff;
   logic [RAD_W-1:0]         q_rem_ff  [SQRT_STEPS];
   logic [RAD_W-1:0]         q_root_ff [SQRT_STEPS];
   logic signed [S_W-1:0]    q_s_ff    [SQRT_STEPS];
   terms_type                q_terms_ff [SQRT_STEPS];
   logic [RAD_W-1:0]         rem_src [SQRT_STEPS];
   logic [RAD_W-1:0]         root_src [SQRT_STEPS];
   logic [RAD_W-1:0]         trial [SQRT_STEPS];
   logic [RAD_W-1:0]         rem_nx [SQRT_STEPS];
   logic [RAD_W-1:0]         root_nx [SQRT_STEPS];
   // CORDIC stages
   logic [CORDIC_LAT-1:0]    d_valid_ff;
   terms_type                t_last;
   logic signed [TERM_W-1:0] pitch_x, pitch_y;
   logic signed [ROLL_W-1:0] pitch_raw, roll_pos, roll_neg, roll_norm, yaw_norm;
   // selection
   logic signed [ROLL_W-1:0] pitch_c;
   logic signed [ROLL_W:0]   dp, dn;
   logic [ROLL_W:0]          dp_abs, dn_abs, tol_ext;
   gimbal_type               gs_in;
   logic                     rsp_valid_ff;
   logic signed [ROLL_W-1:0] roll_ff, roll_in;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic signed [YAW_W-1:0]  yaw_ff, yaw_in;
   gimbal_type               gs_ff;

   // the whole pipeline moves as one while the output slot can take a result
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_roll_angle   = roll_ff;
   assign rsp_pitch_angle  = pitch_ff;
   assign rsp_yaw_angle    = yaw_ff;
   assign rsp_gimbal_state = gs_ff;

   always_comb begin
      a_m20_in       = (TERM_W'(pop_data.xz) - TERM_W'(pop_data.wy)) <<< 1;
      a_terms_in.m21 = (TERM_W'(pop_data.yz) + TERM_W'(pop_data.wx)) <<< 1;
      a_terms_in.m22 = ONE_Q28 - ((TERM_W'(pop_data.xx) + TERM_W'(pop_data.yy)) <<< 1);
      a_terms_in.m10 = (TERM_W'(pop_data.xy) + TERM_W'(pop_data.wz)) <<< 1;
      a_terms_in.m00 = ONE_Q28 - ((TERM_W'(pop_data.yy) + TERM_W'(pop_data.zz)) <<< 1);
      a_terms_in.m01 = (TERM_W'(pop_data.xy) - TERM_W'(pop_data.wz)) <<< 1;
      a_terms_in.m02 = (TERM_W'(pop_data.xz) + TERM_W'(pop_data.wy)) <<< 1;
   end

   always_comb begin
      neg_m20 = -a_m20_ff;
      if (neg_m20 > ONE_Q28) begin
         b_s_in = S_W'(ONE_Q28);
      end else if (neg_m20 < -ONE_Q28) begin
         b_s_in = S_W'(-ONE_Q28);
      end else begin
         b_s_in = S_W'(neg_m20);
      end
      sq = b_s_ff * b_s_ff;
   end

   // bit-pair square root, one pair of bits per stage
   always_comb begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         rem_src[k]  = (k == 0) ? c_rem_ff : q_rem_ff[(k == 0) ? 0 : k - 1];
         root_src[k] = (k == 0) ? '0 : q_root_ff[(k == 0) ? 0 : k - 1];
         trial[k]    = root_src[k] + (RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k)));
         if (rem_src[k] >= trial[k]) begin
            rem_nx[k]  = rem_src[k] - trial[k];
            root_nx[k] = (root_src[k] >> 1) + (RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k)));
         end else begin
            rem_nx[k]  = rem_src[k];
            root_nx[k] = root_src[k] >> 1;
         end
      end
   end

   assign t_last  = q_terms_ff[SQRT_STEPS-1];
   assign pitch_y = TERM_W'(q_s_ff[SQRT_STEPS-1]);
   assign pitch_x = TERM_W'($signed({1'b0, q_root_ff[SQRT_STEPS-1][ROOT_W-1:0]}));

   qte_cordic #(.STEPS(CORDIC_STEPS), .IN_W(TERM_W)) u_pitch (
      .clock(clock), .adv(adv), .in_x(pitch_x), .in_y(pitch_y), .angle(pitch_raw));
   qte_cordic #(.STEPS(CORDIC_STEPS), .IN_W(TERM_W)) u_roll_pos (
      .clock(clock), .adv(adv), .in_x(t_last.m02), .in_y(t_last.m01), .angle(roll_pos));
   qte_cordic #(.STEPS(CORDIC_STEPS), .IN_W(TERM_W)) u_roll_neg (
      .clock(clock), .adv(adv), .in_x(-t_last.m02), .in_y(-t_last.m01), .angle(roll_neg));
   qte_cordic #(.STEPS(CORDIC_STEPS), .IN_W(TERM_W)) u_roll_norm (
      .clock(clock), .adv(adv), .in_x(t_last.m22), .in_y(t_last.m21), .angle(roll_norm));
   qte_cordic #(.STEPS(CORDIC_STEPS), .IN_W(TERM_W)) u_yaw (
      .clock(clock), .adv(adv), .in_x(t_last.m00), .in_y(t_last.m10), .angle(yaw_norm));

   // lock when pitch sits strictly within tolerance of a quarter turn
   always_comb begin
      if (pitch_raw > HALF_LIM) begin
         pitch_c = HALF_LIM;
      end else if (pitch_raw < -HALF_LIM) begin
         pitch_c = -HALF_LIM;
      end else begin
         pitch_c = pitch_raw;
      end
      dp      = (ROLL_W + 1)'(pitch_c) - (ROLL_W + 1)'(HALF_LIM);
      dn      = (ROLL_W + 1)'(pitch_c) + (ROLL_W + 1)'(HALF_LIM);
      dp_abs  = (dp < 0) ? unsigned'(-dp) : unsigned'(dp);
      dn_abs  = (dn < 0) ? unsigned'(-dn) : unsigned'(dn);
      tol_ext = (ROLL_W + 1)'(tol_ff);
      if (dp_abs < tol_ext) begin
         gs_in   = GS_LOCK_POS;
         roll_in = roll_pos;
         yaw_in  = '0;
      end else if (dn_abs < tol_ext) begin
         gs_in   = GS_LOCK_NEG;
         roll_in = roll_neg;
         yaw_in  = '0;
      end else begin
         gs_in   = GS_NORMAL;
         roll_in = roll_norm;
         yaw_in  = yaw_norm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         q_valid_ff   <= '0;
         d_valid_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
         if (adv) begin
            a_valid_ff   <= pop_valid;
            b_valid_ff   <= a_valid_ff;
            c_valid_ff   <= b_valid_ff;
            q_valid_ff   <= {q_valid_ff[SQRT_STEPS-2:0], c_valid_ff};
            d_valid_ff   <= {d_valid_ff[CORDIC_LAT-2:0], q_valid_ff[SQRT_STEPS-1]};
            rsp_valid_ff <= d_valid_ff[CORDIC_LAT-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_m20_ff   <= a_m20_in;
         a_terms_ff <= a_terms_in;
         b_s_ff     <= b_s_in;
         b_terms_ff <= a_terms_ff;
         c_rem_ff   <= ONE_Q56 - RAD_W'(sq);
         c_s_ff     <= b_s_ff;
         c_terms_ff <= b_terms_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            q_rem_ff[k]  <= rem_nx[k];
            q_root_ff[k] <= root_nx[k];
            if (k == 0) begin
               q_s_ff[k]     <= c_s_ff;
               q_terms_ff[k] <= c_terms_ff;
            end else begin
               q_s_ff[k]     <= q_s_ff[(k == 0) ? 0 : k - 1];
               q_terms_ff[k] <= q_terms_ff[(k == 0) ? 0 : k - 1];
            end
         end
         roll_ff  <= roll_in;
         pitch_ff <= PITCH_W'(pitch_c);
         yaw_ff   <= yaw_in;
         gs_ff    <= gs_in;
      end
   end

   a_lock_yaw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && gs_ff != GS_NORMAL |-> yaw_ff == '0)
      else $error("yaw not zero under gimbal lock");

   a_lock_pos_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && gs_ff == GS_LOCK_POS |-> pitch_ff > 0)
      else $error("lock at plus ninety with non-positive pitch");

   a_lock_neg_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && gs_ff == GS_LOCK_NEG |-> pitch_ff < 0)
      else $error("lock at minus ninety with non-negative pitch");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pitch_ff <= PITCH_W'(HALF_PI_Q13)) && (pitch_ff >= -PITCH_W'(HALF_PI_Q13)))
      else $error("pitch beyond a quarter turn");

endmodule

// ----- design/quaternion_to_euler.sv -----
// Top level: unit quaternion to ZYX Euler angles with gimbal lock detection.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_ready      req_quat_w, _x, _y, _z (Q1.14)
//   rsp      out        rsp_valid / rsp_ready      roll, yaw (Q3.13), pitch (Q2.13), gimbal_state
//   csr      in         csr_write_enable           csr_write_data (gimbal tolerance)
//
// One request per cycle sustained while responses are taken; the angle pipeline runs through the
// 29-stage square root feeding the CORDIC pipelines of CORDIC_STEPS + 2 stages.
// Synchronous active-high reset empties the pipeline and sets the tolerance to 1.
// A stalled response holds the angle pipeline; the intake keeps taking requests
// until its own register and its four-entry queue fill.
module quaternion_to_euler #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [qte_pkg::QUAT_W-1:0]   req_quat_w,
   input  logic signed [qte_pkg::QUAT_W-1:0]   req_quat_x,
   input  logic signed [qte_pkg::QUAT_W-1:0]   req_quat_y,
   input  logic signed [qte_pkg::QUAT_W-1:0]   req_quat_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [qte_pkg::ROLL_W-1:0]   rsp_roll_angle,
   output logic signed [qte_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   output logic signed [qte_pkg::YAW_W-1:0]    rsp_yaw_angle,
   output logic [qte_pkg::GS_W-1:0]            rsp_gimbal_state,
   input  logic                                csr_write_enable,
   input  logic [qte_pkg::TOL_W-1:0]           csr_write_data
);
   import qte_pkg::*;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   prod_type push_data, pop_data;

   qte_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data));

   qte_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data));

   qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll_angle(rsp_roll_angle), .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_yaw_angle(rsp_yaw_angle), .rsp_gimbal_state(rsp_gimbal_state));

endmodule

// ----- tb/qte_checker.sv -----
// Checker: predicts Euler angles for each accepted request and compares the responses.
module qte_checker #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_w,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_x,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_y,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_z,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [qte_pkg::ROLL_W-1:0]  rsp_roll_angle,
   input  logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_angle,
   input  logic signed [qte_pkg::YAW_W-1:0]   rsp_yaw_angle,
   input  logic [qte_pkg::GS_W-1:0]           rsp_gimbal_state,
   input  logic                               csr_write_enable,
   input  logic [qte_pkg::TOL_W-1:0]          csr_write_data,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 lock_count
);
   import qte_pkg::*;

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
      gimbal_type                gs;
   } euler_type;

   localparam longint ONE_Q28 = 64'sd1 << 28;

   // atan(2^-i), 2^-24 rad units
   localparam longint ARCTAN_LUT [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   euler_type        angles_due [$];
   logic [TOL_W-1:0] tolerance;
   int               mismatches;

   function automatic longint limit(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned rem, root, bit_v;
      rem = n;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (rem >= root + bit_v) begin
            rem = rem - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return longint'(root);
   endfunction

   function automatic longint arctan2_q13(longint y_in, longint x_in);
      longint y, x, ang, t, dx, dy;
      y = y_in;
      x = x_in;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      // pre-rotate into the right half plane
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; ang = HALF_PI_Z;
         end else begin
            x = -y; y = t; ang = -HALF_PI_Z;
         end
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; ang += ARCTAN_LUT[i];
         end else begin
            x -= dx; y += dy; ang -= ARCTAN_LUT[i];
         end
      end
      return limit((ang + ROUND_BIAS) >>> ROUND_SHIFT, PI_Q13);
   endfunction

   function automatic euler_type euler_of(longint w, longint x, longint y, longint z,
                                          longint tol);
      longint m20, m21, m22, m10, m00, m01, m02, s, c, p, dp, dn, r, yw;
      euler_type e;
      m20 = 2 * (x * z - w * y);
      m21 = 2 * (y * z + w * x);
      m22 = ONE_Q28 - 2 * (x * x + y * y);
      m10 = 2 * (x * y + w * z);
      m00 = ONE_Q28 - 2 * (y * y + z * z);
      m01 = 2 * (x * y - w * z);
      m02 = 2 * (x * z + w * y);
      s = limit(-m20, ONE_Q28);
      c = root_floor((64'd1 << 56) - longint'(s * s));
      p = limit(arctan2_q13(s, c), HALF_PI_Q13);
      dp = p - HALF_PI_Q13;
      dn = p + HALF_PI_Q13;
      if (dp < 0) dp = -dp;
      if (dn < 0) dn = -dn;
      if (dp < tol) begin
         r = arctan2_q13(m01, m02); yw = 0; e.gs = GS_LOCK_POS;
      end else if (dn < tol) begin
         r = arctan2_q13(-m01, -m02); yw = 0; e.gs = GS_LOCK_NEG;
      end else begin
         r = arctan2_q13(m21, m22); yw = arctan2_q13(m10, m00); e.gs = GS_NORMAL;
      end
      e.roll = r[ROLL_W-1:0];
      e.pitch = p[PITCH_W-1:0];
      e.yaw = yw[YAW_W-1:0];
      return e;
   endfunction

   assign pending = angles_due.size();
   assign fail_count = mismatches;

   always @(posedge clock) begin
      euler_type want;
      if (reset) begin
         tolerance <= TOL_RESET;
         angles_due.delete();
         mismatches <= 0;
         lock_count <= 0;
      end else begin
         if (csr_write_enable) tolerance <= csr_write_data;
         if (req_valid && req_ready) begin
            want = euler_of(req_quat_w, req_quat_x, req_quat_y, req_quat_z, tolerance);
            if (want.gs != GS_NORMAL) lock_count <= lock_count + 1;
            angles_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (angles_due.size() == 0) begin
               if (mismatches < 10) $display("unexpected response at %0t", $time);
               mismatches <= mismatches + 1;
            end else begin
               want = angles_due.pop_front();
               if (want.roll !== rsp_roll_angle || want.pitch !== rsp_pitch_angle ||
                   want.yaw !== rsp_yaw_angle || want.gs !== rsp_gimbal_state) begin
                  if (mismatches < 10)
                     $display({"mismatch at %0t: want r=%0d p=%0d y=%0d g=%0d, ",
                               "got r=%0d p=%0d y=%0d g=%0d"},
                              $time, want.roll, want.pitch, want.yaw, want.gs,
                              rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle,
                              rsp_gimbal_state);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: request stimulus, response back-pressure and verdict.
module tb_top;
   import qte_pkg::*;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_ready;
   logic signed [QUAT_W-1:0]  req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic                      rsp_valid;
   logic                      rsp_ready = 0;
   logic signed [ROLL_W-1:0]  rsp_roll_angle;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;
   logic signed [YAW_W-1:0]   rsp_yaw_angle;
   logic [GS_W-1:0]           rsp_gimbal_state;
   logic                      csr_write_enable = 0;
   logic [TOL_W-1:0]          csr_write_data = 0;
   int                        fail_count, pending, lock_count;
   bit                        idle_on = 1;
   bit                        hold_now = 0;
   int                        sent = 0;

   localparam int DRAIN = 60;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   quaternion_to_euler u_top (.*);

   qte_checker u_checker (.*);

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // response side: random stalls, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_now) begin
            rsp_ready <= 0;
            repeat (200) @(posedge clock);
            hold_now = 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic send_quat(int w, int x, int y, int z);
      bit taken;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1;
      req_quat_w <= w[15:0];
      req_quat_x <= x[15:0];
      req_quat_y <= y[15:0];
      req_quat_z <= z[15:0];
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      sent++;
   endtask

   task automatic wait_empty();
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_tolerance(int v);
      req_valid <= 0;
      @(posedge clock);
      wait_empty();
      repeat (DRAIN) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= v[7:0];
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // random unit quaternion, or one close to +/-90 degrees pitch; one in five has raw random components
   task automatic send_random(bit near_lock);
      real a, b, c, d, n;
      if ($urandom_range(0, 4) == 0) begin
         send_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
         if (near_lock) begin
            a = 1.0 + (real'($urandom_range(0, 2000)) - 1000.0) / 20000.0;
            c = ($urandom_range(0, 1) ? 1.0 : -1.0) *
                (1.0 + (real'($urandom_range(0, 2000)) - 1000.0) / 20000.0);
            b = (real'($urandom_range(0, 2000)) - 1000.0) / 20000.0;
            d = (real'($urandom_range(0, 2000)) - 1000.0) / 20000.0;
            if ($urandom_range(0, 1)) begin
               a = -a; b = -b; c = -c; d = -d;
            end
         end else begin
            a = $urandom_range(0, 65535) - 32768.0;
            b = $urandom_range(0, 65535) - 32768.0;
            c = $urandom_range(0, 65535) - 32768.0;
            d = $urandom_range(0, 65535) - 32768.0;
         end
         n = $sqrt(a * a + b * b + c * c + d * d);
         if (n == 0.0) n = 1.0;
         send_quat($rtoi(16384.0 * a / n), $rtoi(16384.0 * b / n),
                   $rtoi(16384.0 * c / n), $rtoi(16384.0 * d / n));
      end
   endtask

   initial begin
      int tols [5];
      tols = '{1, 0, 255, 40, 0};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: identity, axis turns, gimbal poses, extremes, zero
      send_quat(16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);      // negative x, zero y into atan2
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(-16384, 0, 0, 0);
      send_quat(11585, 0, 11585, 0);  // lock at +90
      send_quat(11585, 0, -11585, 0); // lock at -90
      send_quat(11585, 11585, 11585, 11585);
      send_quat(0, 0, 0, 0);          // zero quaternion: all off-diagonal matrix terms zero
      send_quat(16384, 16384, 16384, 16384);
      send_quat(-16384, -16384, -16384, -16384);
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(-32768, 32767, 0, -1);
      send_quat(8192, -8192, 8192, -8192);
      send_quat(11585, 0, 11584, 0);
      send_quat(11584, 0, -11585, 0);

      set_tolerance(255);
      repeat (4) send_quat(11585, 200, 11585, -150);
      set_tolerance(0);
      send_quat(11585, 0, 11585, 0);

      foreach (tols[p]) begin
         set_tolerance(tols[p] == 40 ? $urandom_range(2, 254) : tols[p]);
         if (p == 2) hold_now = 1;  // long hold while requests keep coming
         if (p == 4) idle_on = 0;
         repeat (200) send_random($urandom_range(0, 3) == 0);
      end
      req_valid <= 0;
      @(posedge clock);
      wait_empty();
      repeat (DRAIN) @(posedge clock);
      $display("%0d quaternions converted over five tolerance settings", sent);
      $display("%0d of them reported gimbal lock", lock_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
